@@ design/bmrc_pkg.sv @@
package bmrc_pkg;

   // Field widths of the channels.
   localparam int CHAR_BITS  = 8;
   localparam int COUNT_BITS = 20;
   localparam int TYPE_BITS  = 2;

   // Default stack depth for the top level.
   localparam int STACK_DEPTH_DEFAULT = 1024;

   // Character codes of the openers and closers.
   localparam logic [CHAR_BITS-1:0] CH_OPEN_PAREN   = 8'h28;
   localparam logic [CHAR_BITS-1:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [CHAR_BITS-1:0] CH_OPEN_CURLY   = 8'h7B;
   localparam logic [CHAR_BITS-1:0] CH_OPEN_ANGLE   = 8'h3C;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE_PAREN  = 8'h29;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE_SQUARE = 8'h5D;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE_CURLY  = 8'h7D;
   localparam logic [CHAR_BITS-1:0] CH_CLOSE_ANGLE  = 8'h3E;

   // Bracket type codes kept on the stack.
   localparam logic [TYPE_BITS-1:0] TYPE_PAREN  = 2'd0;
   localparam logic [TYPE_BITS-1:0] TYPE_SQUARE = 2'd1;
   localparam logic [TYPE_BITS-1:0] TYPE_CURLY  = 2'd2;
   localparam logic [TYPE_BITS-1:0] TYPE_ANGLE  = 2'd3;

   // Input item.
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 is_last;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [COUNT_BITS-1:0] replacements;
      logic                  impossible;
   } rsp_type;

   // Operation applied to every cell of the stack in the same cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PUSH,
      OP_POP
   } stack_op_type;

   // Control handed from the top level to the cell chain.
   typedef struct packed {
      stack_op_type         op;
      logic [TYPE_BITS-1:0] code;
   } stack_ctrl_type;

   // Result of classifying a character.
   typedef struct packed {
      logic                 hit;
      logic [TYPE_BITS-1:0] code;
   } bracket_type;

   // Decodes an opener into its type code.
   function automatic bracket_type opener_decode(input logic [CHAR_BITS-1:0] ch);
      bracket_type res;
      res.hit  = 1'b1;
      res.code = TYPE_PAREN;
      unique case (ch)
         CH_OPEN_PAREN:  res.code = TYPE_PAREN;
         CH_OPEN_SQUARE: res.code = TYPE_SQUARE;
         CH_OPEN_CURLY:  res.code = TYPE_CURLY;
         CH_OPEN_ANGLE:  res.code = TYPE_ANGLE;
         default:        res.hit  = 1'b0;
      endcase
      return res;
   endfunction

   // Decodes a closer into the type code that it matches.
   function automatic bracket_type closer_decode(input logic [CHAR_BITS-1:0] ch);
      bracket_type res;
      res.hit  = 1'b1;
      res.code = TYPE_PAREN;
      unique case (ch)
         CH_CLOSE_PAREN:  res.code = TYPE_PAREN;
         CH_CLOSE_SQUARE: res.code = TYPE_SQUARE;
         CH_CLOSE_CURLY:  res.code = TYPE_CURLY;
         CH_CLOSE_ANGLE:  res.code = TYPE_ANGLE;
         default:         res.hit  = 1'b0;
      endcase
      return res;
   endfunction

endpackage

@@ design/bmrc_cell.sv @@
module bmrc_cell (
   input  logic                                clock,
   input  bmrc_pkg::stack_op_type              op,
   input  logic [bmrc_pkg::TYPE_BITS-1:0]      from_above,
   input  logic [bmrc_pkg::TYPE_BITS-1:0]      from_below,
   output logic [bmrc_pkg::TYPE_BITS-1:0]      entry
);

   logic [bmrc_pkg::TYPE_BITS-1:0] entry_ff;
   logic [bmrc_pkg::TYPE_BITS-1:0] entry_in;

   // A push moves every entry one place deeper; a pop moves it one place up.
   always_comb begin
      case (op)
         bmrc_pkg::OP_PUSH: entry_in = from_above;
         bmrc_pkg::OP_POP:  entry_in = from_below;
         default:           entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ design/bmrc_stack.sv @@
module bmrc_stack #(
   parameter int STACK_DEPTH = bmrc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  bmrc_pkg::stack_ctrl_type        ctrl,
   output logic [bmrc_pkg::TYPE_BITS-1:0]  top
);

   logic [bmrc_pkg::TYPE_BITS-1:0] entries [STACK_DEPTH];

   // Cell 0 holds the top of stack; a push enters there and a pop refills
   // each cell from the one below it.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [bmrc_pkg::TYPE_BITS-1:0] above;
      logic [bmrc_pkg::TYPE_BITS-1:0] below;

      if (i == 0) begin : g_first
         assign above = ctrl.code;
      end else begin : g_inner
         assign above = entries[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_body
         assign below = entries[i+1];
      end

      bmrc_cell u_cell (
         .clock      (clock),
         .op         (ctrl.op),
         .from_above (above),
         .from_below (below),
         .entry      (entries[i])
      );
   end

   assign top = entries[0];

endmodule

@@ design/bracket_match_replace_counter.sv @@
// Bracket match and replace counter.
// Characters arrive one per item on the req_ channel (req_valid/req_ready,
// payload req_data), with is_last marking the final character of a string.
// Openers push their type onto a stack built as a chain of cells, with cell 0
// holding the top of stack, so any mix of pushes and pops streams at one item
// per cycle while req_ready is high.
// For the last item of a string one result leaves on the rsp_ channel
// (rsp_valid/rsp_ready, payload rsp_data): the saturating count of
// mismatched closers and the impossible flag. The result is registered and
// appears in the cycle after the last item is accepted.
// Throughput is one item per cycle, with one stall: while a result waits for
// rsp_ready, characters that are not the last of a string are still accepted;
// a further last item waits until the pending result is taken.
// After each result the level, count and failure state clear, and the next
// string starts at once. Synchronous active-high reset clears the same state
// and the result valid flag; the result data and the stack cells are not reset.
module bracket_match_replace_counter #(
   parameter int STACK_DEPTH = bmrc_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bmrc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bmrc_pkg::rsp_type   rsp_data
);

   localparam int LEVEL_BITS = $clog2(STACK_DEPTH + 1);
   localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = LEVEL_BITS'(STACK_DEPTH);
   localparam logic [bmrc_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [LEVEL_BITS-1:0]           level_ff, level_in;
   logic [bmrc_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                            failed_ff, failed_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bmrc_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   bmrc_pkg::bracket_type           opener;
   bmrc_pkg::bracket_type           closer;
   bmrc_pkg::stack_ctrl_type        ctrl;
   logic [bmrc_pkg::TYPE_BITS-1:0]  stack_top;
   logic [LEVEL_BITS-1:0]           level_next;
   logic [bmrc_pkg::COUNT_BITS-1:0] count_next;
   logic                            failed_next;

   // A last item needs the result register free; other items never do.
   assign req_ready  = !rsp_valid_ff || rsp_ready || !req_data.is_last;
   assign req_accept = req_valid && req_ready;

   assign opener = bmrc_pkg::opener_decode(req_data.char_code);
   assign closer = bmrc_pkg::closer_decode(req_data.char_code);

   // Stack chain.
   bmrc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .ctrl  (ctrl),
      .top   (stack_top)
   );

   // Character processing: push, pop with match check, or failure.
   always_comb begin
      ctrl.op     = bmrc_pkg::OP_HOLD;
      ctrl.code   = opener.code;
      level_next  = level_ff;
      count_next  = count_ff;
      failed_next = failed_ff;
      if (req_accept && !failed_ff) begin
         if (opener.hit) begin
            if (level_ff != LEVEL_FULL) begin
               ctrl.op    = bmrc_pkg::OP_PUSH;
               level_next = level_ff + LEVEL_BITS'(1);
            end else begin
               failed_next = 1'b1;
            end
         end else if (level_ff == '0) begin
            failed_next = 1'b1;
         end else begin
            ctrl.op    = bmrc_pkg::OP_POP;
            level_next = level_ff - LEVEL_BITS'(1);
            if (!(closer.hit && closer.code == stack_top) && count_ff != COUNT_MAX) begin
               count_next = count_ff + bmrc_pkg::COUNT_BITS'(1);
            end
         end
      end
   end

   // End of string: build the result and clear the string state.
   always_comb begin
      level_in     = level_next;
      count_in     = count_next;
      failed_in    = failed_next;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && req_data.is_last) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.impossible   = failed_next || (level_next != '0);
         rsp_data_in.replacements = rsp_data_in.impossible ? '0 : count_next;
         level_in                 = '0;
         count_in                 = '0;
         failed_in                = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The level never goes past the number of cells.
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_FULL)
      else $error("stack level beyond depth");

   // A last item leaves the string state cleared.
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.is_last) |=> (level_ff == '0 && count_ff == '0 && !failed_ff))
      else $error("string state not cleared after last item");

   // A new result comes only from an accepted last item.
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) |-> (req_accept && req_data.is_last))
      else $error("result without a last item");

   // An impossible string reports no replacements.
   a_impossible_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.impossible) |-> (rsp_data_ff.replacements == '0))
      else $error("impossible result carries a count");

   // No stack operation once the string has failed.
   a_failed_hold : assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (ctrl.op == bmrc_pkg::OP_HOLD))
      else $error("stack moved after failure");

endmodule

@@ tb/tb_top.sv @@
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = bmrc_pkg::STACK_DEPTH_DEFAULT;
   localparam int NOT_BRACKET  = 4;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int MAX_REPORTS  = 40;

   typedef logic [bmrc_pkg::CHAR_BITS-1:0] char_queue_type[$];

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   bmrc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   bmrc_pkg::rsp_type rsp_data;

   // Expected results, oldest first.
   bmrc_pkg::rsp_type pending_results[$];
   bmrc_pkg::rsp_type oldest_result;

   // Predictor state: opener stack, its level, wrong-closer count and failure.
   logic [bmrc_pkg::TYPE_BITS-1:0]  open_stack [DEPTH];
   int                              open_level = 0;
   logic [bmrc_pkg::COUNT_BITS-1:0] wrong_closers = '0;
   bit                              string_failed = 1'b0;

   // Idle controls and counters used by the sender, the receiver and the tests.
   int req_idle_pct = 25;
   int rsp_idle_pct = 25;
   int rsp_gap_left = 0;
   int next_gap = 0;
   int hold_cycles = 0;
   int live_chars = 0;
   int error_count = 0;
   int cycle_count = 0;

   bracket_match_replace_counter #(
      .STACK_DEPTH(DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Character classification and generation helpers.
   function automatic int opener_type(input logic [bmrc_pkg::CHAR_BITS-1:0] ch);
      case (ch)
         bmrc_pkg::CH_OPEN_PAREN:  return int'(bmrc_pkg::TYPE_PAREN);
         bmrc_pkg::CH_OPEN_SQUARE: return int'(bmrc_pkg::TYPE_SQUARE);
         bmrc_pkg::CH_OPEN_CURLY:  return int'(bmrc_pkg::TYPE_CURLY);
         bmrc_pkg::CH_OPEN_ANGLE:  return int'(bmrc_pkg::TYPE_ANGLE);
         default:                  return NOT_BRACKET;
      endcase
   endfunction

   function automatic int closer_type(input logic [bmrc_pkg::CHAR_BITS-1:0] ch);
      case (ch)
         bmrc_pkg::CH_CLOSE_PAREN:  return int'(bmrc_pkg::TYPE_PAREN);
         bmrc_pkg::CH_CLOSE_SQUARE: return int'(bmrc_pkg::TYPE_SQUARE);
         bmrc_pkg::CH_CLOSE_CURLY:  return int'(bmrc_pkg::TYPE_CURLY);
         bmrc_pkg::CH_CLOSE_ANGLE:  return int'(bmrc_pkg::TYPE_ANGLE);
         default:                   return NOT_BRACKET;
      endcase
   endfunction

   function automatic logic [bmrc_pkg::CHAR_BITS-1:0] opener_of(
      input logic [bmrc_pkg::TYPE_BITS-1:0] t);
      case (t)
         bmrc_pkg::TYPE_PAREN:  return bmrc_pkg::CH_OPEN_PAREN;
         bmrc_pkg::TYPE_SQUARE: return bmrc_pkg::CH_OPEN_SQUARE;
         bmrc_pkg::TYPE_CURLY:  return bmrc_pkg::CH_OPEN_CURLY;
         default:               return bmrc_pkg::CH_OPEN_ANGLE;
      endcase
   endfunction

   function automatic logic [bmrc_pkg::CHAR_BITS-1:0] closer_of(
      input logic [bmrc_pkg::TYPE_BITS-1:0] t);
      case (t)
         bmrc_pkg::TYPE_PAREN:  return bmrc_pkg::CH_CLOSE_PAREN;
         bmrc_pkg::TYPE_SQUARE: return bmrc_pkg::CH_CLOSE_SQUARE;
         bmrc_pkg::TYPE_CURLY:  return bmrc_pkg::CH_CLOSE_CURLY;
         default:               return bmrc_pkg::CH_CLOSE_ANGLE;
      endcase
   endfunction

   // Mostly the right closer, sometimes a random closer or any non-opener byte.
   function automatic logic [bmrc_pkg::CHAR_BITS-1:0] pick_closer(
      input logic [bmrc_pkg::TYPE_BITS-1:0] t);
      logic [bmrc_pkg::CHAR_BITS-1:0] ch;
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 8) return closer_of(t);
      if (roll == 8) return closer_of(bmrc_pkg::TYPE_BITS'($urandom_range(0, 3)));
      do ch = bmrc_pkg::CHAR_BITS'($urandom_range(0, 255));
      while (opener_type(ch) != NOT_BRACKET);
      return ch;
   endfunction

   // Most gaps are zero or short; a few are long.
   function automatic int idle_length(input int idle_pct);
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advances the predictor by one character; returns 1 when a result is due.
   function automatic bit predict_brackets(input bmrc_pkg::req_type item,
                                           output bmrc_pkg::rsp_type res);
      int ot;
      ot = opener_type(item.char_code);
      res = '0;
      if (!string_failed) begin
         if (ot != NOT_BRACKET) begin
            if (open_level < DEPTH) begin
               open_stack[open_level] = bmrc_pkg::TYPE_BITS'(ot);
               open_level++;
            end else begin
               string_failed = 1'b1;
            end
         end else if (open_level == 0) begin
            string_failed = 1'b1;
         end else begin
            open_level--;
            if (closer_type(item.char_code) != int'(open_stack[open_level]) &&
                wrong_closers != '1) begin
               wrong_closers++;
            end
         end
      end
      if (!item.is_last) return 1'b0;
      res.impossible   = string_failed || open_level != 0;
      res.replacements = res.impossible ? '0 : wrong_closers;
      open_level    = 0;
      wrong_closers = '0;
      string_failed = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] result check: %s", $realtime, what);
   endtask

   // Offers one item after a random gap and records its prediction on acceptance.
   task automatic send_char(input bmrc_pkg::req_type item);
      int gap;
      bmrc_pkg::rsp_type res;
      gap = idle_length(req_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!string_failed) live_chars++;
      if (predict_brackets(item, res)) pending_results.push_back(res);
   endtask

   task automatic send_text(input char_queue_type text);
      bmrc_pkg::req_type item;
      int k;
      for (k = 0; k < text.size(); k++) begin
         item.char_code = text[k];
         item.is_last   = (k == text.size() - 1);
         send_char(item);
      end
   endtask

   task automatic send_word(input string s);
      char_queue_type text;
      int k;
      for (k = 0; k < s.len(); k++) text.push_back(s[k]);
      send_text(text);
   endtask

   // Builds a nested bracket string with random types and occasional bad closers.
   task automatic build_nested(input int steps, input int max_depth,
                               output char_queue_type text);
      logic [bmrc_pkg::TYPE_BITS-1:0] open_types[$];
      logic [bmrc_pkg::TYPE_BITS-1:0] t;
      int k;
      text = {};
      for (k = 0; k < steps; k++) begin
         if (open_types.size() == 0 ||
             (open_types.size() < max_depth && $urandom_range(0, 1) == 1)) begin
            t = bmrc_pkg::TYPE_BITS'($urandom_range(0, 3));
            open_types.push_back(t);
            text.push_back(opener_of(t));
         end else begin
            text.push_back(pick_closer(open_types.pop_back()));
         end
      end
      while (open_types.size() != 0) text.push_back(pick_closer(open_types.pop_back()));
   endtask

   // Matched pairs, wrong closers, byte extremes, empty-stack closers, unclosed ends.
   task automatic test_directed_strings();
      char_queue_type text;
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      send_word("()");
      send_word("[]");
      send_word("{}");
      send_word("<>");
      send_word("(][}{><)");
      text = {bmrc_pkg::CH_OPEN_PAREN, 8'h00, bmrc_pkg::CH_OPEN_SQUARE, 8'hFF};
      send_text(text);
      send_word(")((");
      send_word("<");
      send_word("}");
   endtask

   // Fills the stack to its last entry and then pushes one opener too many.
   task automatic test_full_stack();
      char_queue_type text;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      text = {};
      repeat (DEPTH + 1) begin
         text.push_back(opener_of(bmrc_pkg::TYPE_BITS'($urandom_range(0, 3))));
      end
      text.push_back(bmrc_pkg::CH_CLOSE_PAREN);
      send_text(text);
   endtask

   // The receiver holds off while short strings keep coming, so the input stalls.
   task automatic test_back_pressure();
      char_queue_type text;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_cycles  = 300;
      repeat (12) begin
         build_nested($urandom_range(2, 6), 4, text);
         send_text(text);
      end
   endtask

   // Mostly nested strings; the rest are noise and broken strings.
   task automatic test_random_strings();
      char_queue_type text;
      int target;
      int kind;
      int steps;
      target = live_chars + RANDOM_ITEMS;
      while (live_chars < target) begin
         req_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
         rsp_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
         kind  = $urandom_range(0, 99);
         steps = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 16);
         build_nested(steps, ($urandom_range(0, 3) == 0) ? 64 : 8, text);
         if (kind < 15) begin
            text = {};
            repeat (steps) begin
               text.push_back(($urandom_range(0, 3) == 0) ?
                              opener_of(bmrc_pkg::TYPE_BITS'($urandom_range(0, 3))) :
                              bmrc_pkg::CHAR_BITS'($urandom_range(0, 255)));
            end
         end else if (kind < 22) begin
            // A closer before anything has been opened.
            text.push_front(pick_closer(bmrc_pkg::TYPE_BITS'($urandom_range(0, 3))));
         end else if (kind < 29) begin
            if (text.size() > 1) text.delete(text.size() - 1);
         end else if (kind < 35) begin
            text.push_back(opener_of(bmrc_pkg::TYPE_BITS'($urandom_range(0, 3))));
         end
         send_text(text);
      end
   endtask

   // Receiver: checks each accepted result, then decides the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with none expected");
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.replacements !== oldest_result.replacements) begin
               report_mismatch($sformatf("replacements %0d, expected %0d",
                                         rsp_data.replacements, oldest_result.replacements));
            end
            if (rsp_data.impossible !== oldest_result.impossible) begin
               report_mismatch($sformatf("impossible %0b, expected %0b",
                                         rsp_data.impossible, oldest_result.impossible));
            end
         end
      end
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else if (rsp_gap_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap_left--;
      end else begin
         next_gap = idle_length(rsp_idle_pct);
         if (next_gap > 0) begin
            rsp_ready    <= 1'b0;
            rsp_gap_left = next_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("bracket_match_replace_counter: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_full_stack();
      test_back_pressure();
      test_random_strings();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("bracket_match_replace_counter: match");
      end else begin
         $display("bracket_match_replace_counter: mismatch");
      end
      $finish;
   end

endmodule
